// File: hdl/ycl_pkg.sv
// Shared types and constants for the yield curve interpolation table.
// Used by the interfaces, the controller, the datapath and the top level.
package ycl_pkg;

  localparam int unsigned MAX_POINTS_DEF = 32;
  localparam int unsigned MAT_W = 23;
  localparam int unsigned RATE_W = 28;
  localparam int unsigned PROD_W = RATE_W + 1 + MAT_W;
  localparam int unsigned DCNT_W = $clog2(PROD_W);
  localparam logic signed [RATE_W-1:0] DEFAULT_RATE_RST = 28'sd838861;
  localparam logic signed [RATE_W-1:0] RATE_MAX = 28'sh7FFFFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 28'sh8000000;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_SHIFT  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RD_IDX, OP_SCAN, OP_WR_HIT, OP_SET_FULL,
    OP_RD_PM1, OP_MOVE, OP_WR_NEW, OP_RES_DEF, OP_RES_HI, OP_RD_LAST,
    OP_RES_RD, OP_RD_PREV, OP_SAVE_LO, OP_MUL, OP_DIV, OP_FIN,
    OP_IDX_CLR, OP_SH_WR, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic idx_eq_cnt;
    logic idx_zero;
    logic p_eq_idx;
    logic cnt_zero;
    logic full;
    logic lt;
    logic hit;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: hdl/ycl_ifs.sv
// Handshake channel interfaces for commands, results and configuration.
// Depends on ycl_pkg for the field widths.
interface ycl_in_if import ycl_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [MAT_W-1:0] maturity;
  logic signed [RATE_W-1:0] rate_value;
  modport source (output valid, command, maturity, rate_value, input ready);
  modport sink (input valid, command, maturity, rate_value, output ready);
endinterface

interface ycl_out_if import ycl_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [RATE_W-1:0] rate_result;
  logic status;
  modport source (output valid, rate_result, status, input ready);
  modport sink (input valid, rate_result, status, output ready);
endinterface

interface ycl_cfg_if import ycl_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [RATE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hdl/ycl_ctrl.sv
// Sequencing state machine for the yield curve table.
// Depends on ycl_pkg; drives datapath commands from datapath status.
module ycl_ctrl import ycl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_SCAN_RD   = 15'b000000000000010,
    S_SCAN_CMP  = 15'b000000000000100,
    S_DECIDE    = 15'b000000000001000,
    S_MV        = 15'b000000000010000,
    S_MV_WR     = 15'b000000000100000,
    S_LAST_WAIT = 15'b000000001000000,
    S_PREV_WAIT = 15'b000000010000000,
    S_MUL       = 15'b000000100000000,
    S_DIV       = 15'b000001000000000,
    S_FIN       = 15'b000010000000000,
    S_SH        = 15'b000100000000000,
    S_SH_WR     = 15'b001000000000000,
    S_OUT       = 15'b010000000000000,
    S_SPARE     = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    dcmd.op = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op = OP_LOAD;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.idx_eq_cnt) begin
          state_nxt = S_DECIDE;
        end else begin
          dcmd.op = OP_RD_IDX;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        dcmd.op = OP_SCAN;
        state_nxt = stat.lt ? S_SCAN_RD : S_DECIDE;
      end
      S_DECIDE: begin
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.hit) begin
              dcmd.op = OP_WR_HIT;
              state_nxt = S_OUT;
            end else if (stat.full) begin
              dcmd.op = OP_SET_FULL;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_MV;
            end
          end
          CMD_QUERY: begin
            if (stat.cnt_zero) begin
              dcmd.op = OP_RES_DEF;
              state_nxt = S_OUT;
            end else if (stat.hit || stat.idx_zero) begin
              dcmd.op = OP_RES_HI;
              state_nxt = S_OUT;
            end else if (stat.idx_eq_cnt) begin
              dcmd.op = OP_RD_LAST;
              state_nxt = S_LAST_WAIT;
            end else begin
              dcmd.op = OP_RD_PREV;
              state_nxt = S_PREV_WAIT;
            end
          end
          CMD_SHIFT: begin
            dcmd.op = OP_IDX_CLR;
            state_nxt = S_SH;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_MV: begin
        if (stat.p_eq_idx) begin
          dcmd.op = OP_WR_NEW;
          state_nxt = S_OUT;
        end else begin
          dcmd.op = OP_RD_PM1;
          state_nxt = S_MV_WR;
        end
      end
      S_MV_WR: begin
        dcmd.op = OP_MOVE;
        state_nxt = S_MV;
      end
      S_LAST_WAIT: begin
        dcmd.op = OP_RES_RD;
        state_nxt = S_OUT;
      end
      S_PREV_WAIT: begin
        dcmd.op = OP_SAVE_LO;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        dcmd.op = OP_MUL;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dcmd.op = OP_DIV;
        if (stat.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        dcmd.op = OP_FIN;
        state_nxt = S_OUT;
      end
      S_SH: begin
        if (stat.idx_eq_cnt) begin
          state_nxt = S_OUT;
        end else begin
          dcmd.op = OP_RD_IDX;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        dcmd.op = OP_SH_WR;
        state_nxt = S_SH;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          dcmd.op = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/ycl_dp.sv
// Datapath of the yield curve table: point memories, counters, multiplier,
// serial divider and result register. Depends on ycl_pkg.
module ycl_dp import ycl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  dcmd,
  output dp_stat_t                 stat,
  input  logic [1:0]               in_command,
  input  logic [MAT_W-1:0]         in_maturity,
  input  logic signed [RATE_W-1:0] in_rate_value,
  input  logic                     cfg_we,
  input  logic signed [RATE_W-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RATE_W-1:0] out_rate_result,
  output logic                     out_status
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [MAT_W-1:0]         mat_mem [MAX_POINTS];
  logic signed [RATE_W-1:0] rate_mem [MAX_POINTS];
  logic [MAT_W-1:0]         rd_mat_r;
  logic signed [RATE_W-1:0] rd_rate_r;

  logic [CW-1:0] count_r, idx_r, p_r;
  logic [1:0] cmd_r;
  logic [MAT_W-1:0] m_r, t_hi_r, t_lo_r, dt_r, rem_r;
  logic signed [RATE_W-1:0] rv_r, r_hi_r, r_lo_r, def_r, res_r;
  logic status_r, hit_r, neg_r;
  logic [PROD_W-1:0] quo_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic out_valid_r;
  logic signed [RATE_W-1:0] out_rate_r;
  logic out_status_r;

  logic [CW-1:0] ra_full;
  logic [AW-1:0] ra, wa;
  logic we_mat, we_rate;
  logic [MAT_W-1:0] wd_mat;
  logic signed [RATE_W-1:0] wd_rate;
  logic signed [RATE_W:0] dr, sh_sum, sq, fin_sum;
  logic [RATE_W:0] dr_mag;
  logic [MAT_W-1:0] dm;
  logic [MAT_W:0] trial, trial_sub;
  logic ge;

  always_comb begin
    case (dcmd.op)
      OP_RD_PM1:  ra_full = p_r - CW'(1);
      OP_RD_LAST: ra_full = count_r - CW'(1);
      OP_RD_PREV: ra_full = idx_r - CW'(1);
      default:    ra_full = idx_r;
    endcase
    ra = ra_full[AW-1:0];
  end

  assign sh_sum = {rd_rate_r[RATE_W-1], rd_rate_r} + {rv_r[RATE_W-1], rv_r};

  always_comb begin
    we_mat = 1'b0;
    we_rate = 1'b0;
    wa = idx_r[AW-1:0];
    wd_mat = m_r;
    wd_rate = rv_r;
    case (dcmd.op)
      OP_WR_HIT: we_rate = 1'b1;
      OP_WR_NEW: begin
        we_mat = 1'b1;
        we_rate = 1'b1;
      end
      OP_MOVE: begin
        we_mat = 1'b1;
        we_rate = 1'b1;
        wa = p_r[AW-1:0];
        wd_mat = rd_mat_r;
        wd_rate = rd_rate_r;
      end
      OP_SH_WR: begin
        we_rate = 1'b1;
        if (sh_sum > $signed({RATE_MAX[RATE_W-1], RATE_MAX})) begin
          wd_rate = RATE_MAX;
        end else if (sh_sum < $signed({RATE_MIN[RATE_W-1], RATE_MIN})) begin
          wd_rate = RATE_MIN;
        end else begin
          wd_rate = sh_sum[RATE_W-1:0];
        end
      end
      default: we_mat = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_mat) begin
      mat_mem[wa] <= wd_mat;
    end
    if (we_rate) begin
      rate_mem[wa] <= wd_rate;
    end
    rd_mat_r <= mat_mem[ra];
    rd_rate_r <= rate_mem[ra];
  end

  assign dr = {r_hi_r[RATE_W-1], r_hi_r} - {r_lo_r[RATE_W-1], r_lo_r};
  assign dr_mag = dr[RATE_W] ? (RATE_W+1)'(0) - dr : dr;
  assign dm = m_r - t_lo_r;
  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign trial_sub = trial - {1'b0, dt_r};
  assign ge = (trial >= {1'b0, dt_r});
  assign sq = neg_r ? -$signed(quo_r[RATE_W:0]) : $signed(quo_r[RATE_W:0]);
  assign fin_sum = {r_lo_r[RATE_W-1], r_lo_r} + sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      def_r <= DEFAULT_RATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        def_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (dcmd.op)
        OP_WR_NEW: count_r <= count_r + CW'(1);
        OP_PUSH:   out_valid_r <= 1'b1;
        default:   count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_LOAD: begin
        cmd_r <= in_command;
        m_r <= in_maturity;
        rv_r <= in_rate_value;
        idx_r <= '0;
        p_r <= count_r;
        hit_r <= 1'b0;
        res_r <= '0;
        status_r <= 1'b0;
      end
      OP_SCAN: begin
        t_hi_r <= rd_mat_r;
        r_hi_r <= rd_rate_r;
        if (rd_mat_r < m_r) begin
          idx_r <= idx_r + CW'(1);
        end else begin
          hit_r <= (rd_mat_r == m_r);
        end
      end
      OP_SET_FULL: status_r <= 1'b1;
      OP_MOVE:     p_r <= p_r - CW'(1);
      OP_RES_DEF:  res_r <= def_r;
      OP_RES_HI:   res_r <= r_hi_r;
      OP_RES_RD:   res_r <= rd_rate_r;
      OP_SAVE_LO: begin
        t_lo_r <= rd_mat_r;
        r_lo_r <= rd_rate_r;
      end
      OP_MUL: begin
        quo_r <= PROD_W'(dr_mag * dm);
        neg_r <= dr[RATE_W];
        dt_r <= t_hi_r - t_lo_r;
        rem_r <= '0;
        dcnt_r <= DCNT_W'(PROD_W - 1);
      end
      OP_DIV: begin
        rem_r <= ge ? trial_sub[MAT_W-1:0] : trial[MAT_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], ge};
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      OP_FIN:     res_r <= fin_sum[RATE_W-1:0];
      OP_IDX_CLR: idx_r <= '0;
      OP_SH_WR:   idx_r <= idx_r + CW'(1);
      OP_PUSH: begin
        out_rate_r <= res_r;
        out_status_r <= status_r;
      end
      default: res_r <= res_r;
    endcase
  end

  assign stat.cmd = cmd_t'(cmd_r);
  assign stat.idx_eq_cnt = (idx_r == count_r);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.p_eq_idx = (p_r == idx_r);
  assign stat.cnt_zero = (count_r == '0);
  assign stat.full = (count_r == CW'(MAX_POINTS));
  assign stat.lt = (rd_mat_r < m_r);
  assign stat.hit = hit_r;
  assign stat.div_last = (dcnt_r == '0);
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_rate_result = out_rate_r;
  assign out_status = out_status_r;

endmodule

// File: hdl/yield_curve_linear_interp_table.sv
// Yield curve table with piecewise linear interpolation: one command word in,
// one result word out. A command scans the stored points; an insert may then
// move points and a shift steps through every stored point; an interpolating
// query runs the one-bit-per-cycle serial divider over the 52-bit product.
// One command is worked on at a time.
module yield_curve_linear_interp_table import ycl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ycl_in_if.sink     in_ch,
  ycl_out_if.source  out_ch,
  ycl_cfg_if.sink    cfg_ch
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ycl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  ycl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dcmd            (dcmd),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_maturity     (in_ch.maturity),
    .in_rate_value   (in_ch.rate_value),
    .cfg_we          (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_rate_result (out_ch.rate_result),
    .out_status      (out_ch.status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("Command word accepted while one is in progress.");

  a_status_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.rate_result == '0)
    else $error("Table full result carries a nonzero rate.");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("Result valid after reset.");

endmodule
